// ----- sv/tes_pkg.sv -----
// Package for the triangle element stiffness block: widths, lane pairing and the divider item.
// Used by every other file of the block. It depends on nothing.
package tes_pkg;

	localparam int NODE_COUNT_DEF = 1024;

	localparam int NODE_W = 11;
	localparam int ROW_W  = 10;
	localparam int CRD_W  = 16;
	localparam int DIF_W  = 17;
	localparam int PROD_W = 34;
	localparam int SUM_W  = 35;
	localparam int DEN_W  = 36;
	localparam int DIVD_W = 52;
	localparam int Q_W    = 32;
	localparam int LANES  = 6;
	localparam int QUO_STEPS = 32;
	localparam int FRAC_W = 16;
	localparam int HI_W   = 5;
	localparam int LO_W   = 6;
	localparam int RES_W  = 17;

	// Lanes are ordered aa, bb, cc, ab, ac, bc.
	localparam logic [1:0] PAIR_I [LANES] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd1};
	localparam logic [1:0] PAIR_J [LANES] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

	localparam logic [Q_W-1:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [Q_W-1:0] NEG_MIN = 32'h8000_0000;

	// One triangle inside the divider. The lq field holds the dividend bits
	// still to be consumed at its top and the quotient bits gathered at its bottom.
	typedef struct packed {
		logic [DEN_W-1:0]                den;
		logic [LANES-1:0]                neg;
		logic [LANES-1:0]                ovf;
		logic [LANES-1:0][DEN_W-1:0]     rem;
		logic [LANES-1:0][Q_W-1:0]       lq;
		logic                            degen;
		logic [ROW_W-1:0]                row_a;
		logic [ROW_W-1:0]                row_b;
		logic [ROW_W-1:0]                row_c;
	} div_item_t;

endpackage

// ----- sv/tes_in_if.sv -----
// Input channel of the triangle element stiffness block: one triangle per transaction.
// Depends on tes_pkg for field widths.
interface tes_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [tes_pkg::NODE_W-1:0]           node_a;
	logic [tes_pkg::NODE_W-1:0]           node_b;
	logic [tes_pkg::NODE_W-1:0]           node_c;
	logic signed [tes_pkg::CRD_W-1:0]     ax;
	logic signed [tes_pkg::CRD_W-1:0]     ay;
	logic signed [tes_pkg::CRD_W-1:0]     bx;
	logic signed [tes_pkg::CRD_W-1:0]     by;
	logic signed [tes_pkg::CRD_W-1:0]     cx;
	logic signed [tes_pkg::CRD_W-1:0]     cy;

	modport source (output valid, node_a, node_b, node_c, ax, ay, bx, by, cx, cy,
		input ready);
	modport sink (input valid, node_a, node_b, node_c, ax, ay, bx, by, cx, cy,
		output ready);
endinterface

// ----- sv/tes_out_if.sv -----
// Output channel of the triangle element stiffness block: rows and six entries per transaction.
// Depends on tes_pkg for field widths.
interface tes_out_if;
	logic                              valid;
	logic                              ready;
	logic [tes_pkg::ROW_W-1:0]         row_a;
	logic [tes_pkg::ROW_W-1:0]         row_b;
	logic [tes_pkg::ROW_W-1:0]         row_c;
	logic signed [tes_pkg::Q_W-1:0]    k_aa;
	logic signed [tes_pkg::Q_W-1:0]    k_bb;
	logic signed [tes_pkg::Q_W-1:0]    k_cc;
	logic signed [tes_pkg::Q_W-1:0]    k_ab;
	logic signed [tes_pkg::Q_W-1:0]    k_ac;
	logic signed [tes_pkg::Q_W-1:0]    k_bc;
	logic                              degenerate;

	modport source (output valid, row_a, row_b, row_c, k_aa, k_bb, k_cc, k_ab, k_ac, k_bc,
		degenerate, input ready);
	modport sink (input valid, row_a, row_b, row_c, k_aa, k_bb, k_cc, k_ab, k_ac, k_bc,
		degenerate, output ready);
endinterface

// ----- sv/tes_front.sv -----
// Geometry front end: row indices, edge differences, products, sums and divider setup.
// Five register stages. Depends on tes_pkg and tes_in_if.
module tes_front #(
	parameter int NODE_COUNT = tes_pkg::NODE_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	tes_in_if.sink             elem,
	output logic               v_out,
	output tes_pkg::div_item_t item_out
);

	localparam int L = tes_pkg::LANES;

	logic [tes_pkg::RES_W-1:0] hi_tab [2**tes_pkg::HI_W];
	logic [tes_pkg::RES_W-1:0] lo_tab [2**tes_pkg::LO_W];

	for (genvar g = 0; g < 2**tes_pkg::HI_W; g++) begin : g_hi
		localparam int HiRes = (g * (2**tes_pkg::LO_W)) % NODE_COUNT;
		assign hi_tab[g] = tes_pkg::RES_W'(HiRes);
	end
	for (genvar g = 0; g < 2**tes_pkg::LO_W; g++) begin : g_lo
		localparam int LoRes = (g + NODE_COUNT - 1) % NODE_COUNT;
		assign lo_tab[g] = tes_pkg::RES_W'(LoRes);
	end

	logic [tes_pkg::NODE_W-1:0] node_v [3];
	logic [tes_pkg::ROW_W-1:0]  row_d [3];
	assign node_v[0] = elem.node_a;
	assign node_v[1] = elem.node_b;
	assign node_v[2] = elem.node_c;

	for (genvar n = 0; n < 3; n++) begin : g_row
		logic [tes_pkg::RES_W:0] sum;
		logic [tes_pkg::RES_W:0] red;
		assign sum = {1'b0, hi_tab[node_v[n][tes_pkg::NODE_W-1:tes_pkg::LO_W]]}
			+ {1'b0, lo_tab[node_v[n][tes_pkg::LO_W-1:0]]};
		assign red = (sum >= (tes_pkg::RES_W+1)'(NODE_COUNT))
			? sum - (tes_pkg::RES_W+1)'(NODE_COUNT) : sum;
		assign row_d[n] = red[tes_pkg::ROW_W-1:0];
	end

	assign elem.ready = en;

	// Stage 1: rows and edge differences.
	logic                                 v_s1;
	logic [tes_pkg::ROW_W-1:0]            row_s1 [3];
	logic signed [tes_pkg::DIF_W-1:0]     bv_s1 [3];
	logic signed [tes_pkg::DIF_W-1:0]     cv_s1 [3];
	// Stage 2: products.
	logic                                 v_s2;
	logic [tes_pkg::ROW_W-1:0]            row_s2 [3];
	logic signed [tes_pkg::PROD_W-1:0]    pb_s2 [L];
	logic signed [tes_pkg::PROD_W-1:0]    pc_s2 [L];
	logic signed [tes_pkg::PROD_W-1:0]    d0_s2;
	logic signed [tes_pkg::PROD_W-1:0]    d1_s2;
	// Stage 3: numerators and twice the signed area.
	logic                                 v_s3;
	logic [tes_pkg::ROW_W-1:0]            row_s3 [3];
	logic signed [tes_pkg::SUM_W-1:0]     num_s3 [L];
	logic signed [tes_pkg::SUM_W-1:0]     d_s3;
	// Stage 4: magnitudes, divisor and rounded dividend.
	logic                                 v_s4;
	logic [tes_pkg::ROW_W-1:0]            row_s4 [3];
	logic [L-1:0]                         neg_s4;
	logic [tes_pkg::DIVD_W-1:0]           divd_s4 [L];
	logic [tes_pkg::DEN_W-1:0]            den_s4;
	logic                                 degen_s4;
	// Stage 5: divider setup.
	logic                                 v_s5;
	tes_pkg::div_item_t                   item_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= elem.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	logic [tes_pkg::SUM_W-1:0] dabs;
	assign dabs = d_s3[tes_pkg::SUM_W-1] ? tes_pkg::SUM_W'(-d_s3) : tes_pkg::SUM_W'(d_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			row_s1 <= row_d;
			bv_s1[0] <= tes_pkg::DIF_W'(elem.by) - tes_pkg::DIF_W'(elem.cy);
			bv_s1[1] <= tes_pkg::DIF_W'(elem.cy) - tes_pkg::DIF_W'(elem.ay);
			bv_s1[2] <= tes_pkg::DIF_W'(elem.ay) - tes_pkg::DIF_W'(elem.by);
			cv_s1[0] <= tes_pkg::DIF_W'(elem.cx) - tes_pkg::DIF_W'(elem.bx);
			cv_s1[1] <= tes_pkg::DIF_W'(elem.ax) - tes_pkg::DIF_W'(elem.cx);
			cv_s1[2] <= tes_pkg::DIF_W'(elem.bx) - tes_pkg::DIF_W'(elem.ax);

			row_s2 <= row_s1;
			for (int k = 0; k < L; k++) begin
				pb_s2[k] <= tes_pkg::PROD_W'(bv_s1[tes_pkg::PAIR_I[k]])
					* tes_pkg::PROD_W'(bv_s1[tes_pkg::PAIR_J[k]]);
				pc_s2[k] <= tes_pkg::PROD_W'(cv_s1[tes_pkg::PAIR_I[k]])
					* tes_pkg::PROD_W'(cv_s1[tes_pkg::PAIR_J[k]]);
			end
			d0_s2 <= tes_pkg::PROD_W'(cv_s1[2]) * tes_pkg::PROD_W'(bv_s1[1]);
			d1_s2 <= tes_pkg::PROD_W'(bv_s1[2]) * tes_pkg::PROD_W'(cv_s1[1]);

			row_s3 <= row_s2;
			for (int k = 0; k < L; k++) begin
				num_s3[k] <= tes_pkg::SUM_W'(pb_s2[k]) + tes_pkg::SUM_W'(pc_s2[k]);
			end
			d_s3 <= tes_pkg::SUM_W'(d0_s2) - tes_pkg::SUM_W'(d1_s2);

			row_s4 <= row_s3;
			for (int k = 0; k < L; k++) begin
				neg_s4[k] <= num_s3[k][tes_pkg::SUM_W-1];
				divd_s4[k] <= tes_pkg::DIVD_W'({(num_s3[k][tes_pkg::SUM_W-1]
					? tes_pkg::SUM_W'(-num_s3[k]) : tes_pkg::SUM_W'(num_s3[k])),
					{tes_pkg::FRAC_W{1'b0}}}) + tes_pkg::DIVD_W'(dabs);
			end
			den_s4   <= {dabs, 1'b0};
			degen_s4 <= (d_s3 == '0);

			item_s5.row_a <= row_s4[0];
			item_s5.row_b <= row_s4[1];
			item_s5.row_c <= row_s4[2];
			item_s5.degen <= degen_s4;
			item_s5.den   <= den_s4;
			item_s5.neg   <= neg_s4;
			for (int k = 0; k < L; k++) begin
				// A quotient of 2^32 or more saturates whatever its low bits are.
				item_s5.ovf[k] <= tes_pkg::DEN_W'(divd_s4[k][tes_pkg::DIVD_W-1:tes_pkg::Q_W])
					>= den_s4;
				item_s5.rem[k] <= tes_pkg::DEN_W'(divd_s4[k][tes_pkg::DIVD_W-1:tes_pkg::Q_W]);
				item_s5.lq[k]  <= divd_s4[k][tes_pkg::Q_W-1:0];
			end
		end
	end

	assign v_out    = v_s5;
	assign item_out = item_s5;

endmodule

// ----- sv/tes_div_stage.sv -----
// One restoring-division step for all six lanes: one quotient bit per lane per stage.
// Depends on tes_pkg.
module tes_div_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               v_in,
	input  tes_pkg::div_item_t item_in,
	output logic               v_out,
	output tes_pkg::div_item_t item_out
);

	tes_pkg::div_item_t nxt;

	always_comb begin
		logic [tes_pkg::DEN_W:0] r2;
		logic                    ge;
		nxt = item_in;
		for (int k = 0; k < tes_pkg::LANES; k++) begin
			r2 = {item_in.rem[k], item_in.lq[k][tes_pkg::Q_W-1]};
			ge = r2 >= {1'b0, item_in.den};
			nxt.rem[k] = ge ? tes_pkg::DEN_W'(r2 - {1'b0, item_in.den}) : tes_pkg::DEN_W'(r2);
			nxt.lq[k]  = {item_in.lq[k][tes_pkg::Q_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_out <= nxt;
		end
	end

endmodule

// ----- sv/triangle_element_stiffness.sv -----
// An accepted input transaction passes through five front-end stages, 32 restoring-division
// stages and one output register before it leaves as an output transaction.
// Throughput: one triangle per cycle unless the output stalls; the 32-stage divider sets depth.
// A stall at the output freezes the whole pipeline, so nothing is lost or repeated.
// Reset (arst_n low, asynchronous) clears all valid bits; payload registers are not reset.
module triangle_element_stiffness #(
	parameter int NODE_COUNT = tes_pkg::NODE_COUNT_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	tes_in_if.sink   elem,
	tes_out_if.source result
);

	localparam int STEPS = tes_pkg::QUO_STEPS;
	localparam int L     = tes_pkg::LANES;

	// The whole pipeline advances together whenever the output register is
	// empty or its transaction is taken this cycle.
	logic en;
	assign en = !result.valid || result.ready;

	// Valid bits and items along the divider chain; index zero is the front end output.
	logic               vch [STEPS+1];
	tes_pkg::div_item_t ich [STEPS+1];

	tes_front #(.NODE_COUNT(NODE_COUNT)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.elem     (elem),
		.v_out    (vch[0]),
		.item_out (ich[0])
	);

	for (genvar s = 0; s < STEPS; s++) begin : g_div
		tes_div_stage u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.v_in     (vch[s]),
			.item_in  (ich[s]),
			.v_out    (vch[s+1]),
			.item_out (ich[s+1])
		);
	end

	// Sign, saturation and the degenerate override. The quotient is already
	// rounded because half the divisor was added to the dividend up front.
	logic [tes_pkg::Q_W-1:0] k_d [L];
	always_comb begin
		logic [tes_pkg::Q_W-1:0] q;
		for (int k = 0; k < L; k++) begin
			q = ich[STEPS].lq[k];
			if (ich[STEPS].degen) begin
				k_d[k] = '0;
			end else if (ich[STEPS].neg[k]) begin
				k_d[k] = (ich[STEPS].ovf[k] || q > tes_pkg::NEG_MIN) ? tes_pkg::NEG_MIN : -q;
			end else begin
				k_d[k] = (ich[STEPS].ovf[k] || q[tes_pkg::Q_W-1]) ? tes_pkg::POS_MAX : q;
			end
		end
	end

	logic                    v_q;
	logic [tes_pkg::Q_W-1:0] k_q [L];
	logic [tes_pkg::ROW_W-1:0] row_a_q, row_b_q, row_c_q;
	logic                    degen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= vch[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_q     <= k_d;
			row_a_q <= ich[STEPS].row_a;
			row_b_q <= ich[STEPS].row_b;
			row_c_q <= ich[STEPS].row_c;
			degen_q <= ich[STEPS].degen;
		end
	end

	assign result.valid      = v_q;
	assign result.row_a      = row_a_q;
	assign result.row_b      = row_b_q;
	assign result.row_c      = row_c_q;
	assign result.k_aa       = k_q[0];
	assign result.k_bb       = k_q[1];
	assign result.k_cc       = k_q[2];
	assign result.k_ab       = k_q[3];
	assign result.k_ac       = k_q[4];
	assign result.k_bc       = k_q[5];
	assign result.degenerate = degen_q;

	// A degenerate triangle must come out with all entries cleared.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.degenerate |-> result.k_aa == '0 && result.k_bb == '0 &&
		result.k_cc == '0 && result.k_ab == '0 && result.k_ac == '0 && result.k_bc == '0)
		else $error("degenerate result with nonzero entries");

	// Diagonal entries come from sums of squares and are never negative.
	a_diag_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !result.k_aa[tes_pkg::Q_W-1] && !result.k_bb[tes_pkg::Q_W-1] &&
		!result.k_cc[tes_pkg::Q_W-1])
		else $error("negative diagonal entry");

	// Row indices stay inside the node range.
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> int'(result.row_a) < NODE_COUNT && int'(result.row_b) < NODE_COUNT &&
		int'(result.row_c) < NODE_COUNT)
		else $error("row index out of range");

endmodule

// ----- test/tb_tes_if.sv -----
// Testbench-side copies of nothing: the block's own interfaces are used directly.
// This file holds a small record type shared by the testbench top; depends on tes_pkg.
package tb_tes_types;
	import tes_pkg::*;

	typedef struct {
		logic [ROW_W-1:0]        row_a;
		logic [ROW_W-1:0]        row_b;
		logic [ROW_W-1:0]        row_c;
		logic signed [Q_W-1:0]   k [LANES];
		logic                    degenerate;
	} stiffness_t;
endpackage

// ----- test/tb.sv -----
// Testbench for triangle_element_stiffness: drives triangles through the input channel and
// compares each output transaction with an internally computed stiffness row set.
// Depends on tes_pkg, tes_in_if, tes_out_if, tb_tes_types and the block RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tes_pkg::*;
	import tb_tes_types::*;

	localparam int NODES = NODE_COUNT_DEF;
	localparam int LATENCY = 38;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	tes_in_if elem ();
	tes_out_if result ();

	triangle_element_stiffness i_dut (.clk(clk), .arst_n(arst_n), .elem(elem), .result(result));

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	stiffness_t expected_rows[$];
	int errors = 0;
	longint cycle = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// Zero-based row of a one-based node number, wrapping node zero and large numbers.
	function automatic logic [ROW_W-1:0] node_row(logic [NODE_W-1:0] node);
		return ROW_W'((longint'(node) + NODES - 1) % NODES);
	endfunction

	// Q16.16 entry num/(2|D|), rounded half away from zero and saturated.
	function automatic logic signed [Q_W-1:0] q16_entry(longint num, longint dabs);
		logic neg;
		longint unsigned mag, q;
		neg = num < 0;
		mag = neg ? -num : num;
		q = (mag * 65536 + dabs) / (2 * dabs);
		if (neg) begin
			if (q > 64'h8000_0000) q = 64'h8000_0000;
			return Q_W'(-q);
		end
		if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
		return Q_W'(q);
	endfunction

	function automatic stiffness_t element_stiffness(logic [NODE_W-1:0] na, nb, nc,
			logic signed [CRD_W-1:0] ax, ay, bx, by, cx, cy);
		stiffness_t s;
		longint b[3], c[3], d, dabs;
		b[0] = by - cy; b[1] = cy - ay; b[2] = ay - by;
		c[0] = cx - bx; c[1] = ax - cx; c[2] = bx - ax;
		d = longint'(ax) * b[0] + longint'(bx) * b[1] + longint'(cx) * b[2];
		s.row_a = node_row(na);
		s.row_b = node_row(nb);
		s.row_c = node_row(nc);
		s.degenerate = (d == 0);
		dabs = d < 0 ? -d : d;
		// Lane order follows the package pairing: aa, bb, cc, ab, ac, bc.
		for (int l = 0; l < LANES; l++)
			s.k[l] = (d == 0) ? '0 : q16_entry(b[PAIR_I[l]] * b[PAIR_J[l]]
				+ c[PAIR_I[l]] * c[PAIR_J[l]], dabs);
		return s;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		errors++;
		$display("mismatch at cycle %0d: %s got %0h expected %0h", cycle, field, got, want);
	endtask

	// Sends one triangle: the valid stays high across back-to-back transactions and is
	// dropped only by an idle cycle or by the drain wait.
	task automatic send_triangle(logic [NODE_W-1:0] na, nb, nc,
			logic signed [CRD_W-1:0] ax, ay, bx, by, cx, cy);
		while ($urandom_range(99) < send_idle_pct) begin
			elem.valid <= 1'b0;
			@(posedge clk);
		end
		elem.valid <= 1'b1;
		elem.node_a <= na; elem.node_b <= nb; elem.node_c <= nc;
		elem.ax <= ax; elem.ay <= ay; elem.bx <= bx;
		elem.by <= by; elem.cx <= cx; elem.cy <= cy;
		expected_rows.push_back(element_stiffness(na, nb, nc, ax, ay, bx, by, cx, cy));
		do @(posedge clk); while (!elem.ready);
	endtask

	function automatic logic signed [CRD_W-1:0] rand_coord();
		case ($urandom_range(3))
			0: return CRD_W'($urandom);
			1: return CRD_W'($signed($urandom_range(40)) - 20);
			2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			default: return CRD_W'($signed($urandom_range(2000)) - 1000);
		endcase
	endfunction

	function automatic logic [NODE_W-1:0] rand_node();
		return ($urandom_range(9) == 0) ? NODE_W'($urandom) : NODE_W'($urandom_range(NODES, 1));
	endfunction

	task automatic wait_drained();
		elem.valid <= 1'b0;
		while (expected_rows.size() != 0) @(posedge clk);
	endtask

	// Checker: every accepted output transaction is compared with the oldest expectation.
	always @(posedge clk) begin
		stiffness_t want;
		string names[LANES];
		names = '{"k_aa", "k_bb", "k_cc", "k_ab", "k_ac", "k_bc"};
		cycle <= cycle + 1;
		if (arst_n && result.valid && result.ready) begin
			if (expected_rows.size() == 0) begin
				errors++;
				$display("unexpected output transaction at cycle %0d", cycle);
			end else begin
				want = expected_rows.pop_front();
				if (result.row_a !== want.row_a) report_mismatch("row_a", result.row_a, want.row_a);
				if (result.row_b !== want.row_b) report_mismatch("row_b", result.row_b, want.row_b);
				if (result.row_c !== want.row_c) report_mismatch("row_c", result.row_c, want.row_c);
				if (result.k_aa !== want.k[0]) report_mismatch(names[0], result.k_aa, want.k[0]);
				if (result.k_bb !== want.k[1]) report_mismatch(names[1], result.k_bb, want.k[1]);
				if (result.k_cc !== want.k[2]) report_mismatch(names[2], result.k_cc, want.k[2]);
				if (result.k_ab !== want.k[3]) report_mismatch(names[3], result.k_ab, want.k[3]);
				if (result.k_ac !== want.k[4]) report_mismatch(names[4], result.k_ac, want.k[4]);
				if (result.k_bc !== want.k[5]) report_mismatch(names[5], result.k_bc, want.k[5]);
				if (result.degenerate !== want.degenerate)
					report_mismatch("degenerate", result.degenerate, want.degenerate);
			end
		end
		// The receiver stalls at random; it is held low while reset is asserted.
		result.ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	// The run stops here if the block hangs.
	always @(posedge clk) begin
		if (cycle > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Corners: extreme nodes, extreme coordinates, degenerate and sliver shapes.
	task automatic test_directed();
		send_triangle(1, 2, 3, 0, 0, 1, 0, 0, 1);                   // unit right triangle
		send_triangle(1024, 1023, 1, 0, 0, 0, 1, 1, 0);             // clockwise, top node
		send_triangle(0, 2047, 1025, 0, 0, 1, 0, 0, 1);             // node wrap cases
		send_triangle(5, 6, 7, 3, 3, 3, 3, 3, 3);                   // all points equal
		send_triangle(5, 6, 7, 0, 0, 1, 1, 2, 2);                   // collinear
		send_triangle(8, 9, 10, -32768, -32768, 32767, -32768, -32768, 32767);
		send_triangle(8, 9, 10, 32767, 32767, -32768, 32767, 32767, -32768);
		send_triangle(1, 2, 3, -32768, 0, 32767, 0, 0, 1);          // sliver: entries near the limit
		send_triangle(1, 2, 3, -32768, 0, 32767, 0, 0, -1);
		send_triangle(1, 2, 3, 0, 0, 2, 0, 1, 1);                   // small area: exact quotients
		send_triangle(1, 2, 3, 0, 0, 3, 0, 0, 7);
		send_triangle(1, 2, 3, -1, -1, -1, -1, -1, -1);
		send_triangle(2047, 2047, 2047, 0, 0, 65535 % 32768, 0, 0, 32767);
		send_triangle(11, 12, 13, 32767, 32767, 32767, 32767, -32768, -32768);
	endtask

	task automatic test_random(int count);
		logic signed [CRD_W-1:0] ax, ay, bx, by;
		for (int n = 0; n < count; n++) begin
			ax = rand_coord(); ay = rand_coord(); bx = rand_coord(); by = rand_coord();
			if ($urandom_range(19) == 0)      // occasional degenerate: repeat a vertex
				send_triangle(rand_node(), rand_node(), rand_node(), ax, ay, bx, by, ax, ay);
			else
				send_triangle(rand_node(), rand_node(), rand_node(), ax, ay, bx, by,
					rand_coord(), rand_coord());
		end
	endtask

	initial begin
		elem.valid = 1'b0;
		elem.node_a = '0; elem.node_b = '0; elem.node_c = '0;
		elem.ax = '0; elem.ay = '0; elem.bx = '0; elem.by = '0; elem.cx = '0; elem.cy = '0;
		result.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		send_idle_pct = 35; recv_stall_pct = 75;
		test_random(580);
		// Hold off until the pipeline has emptied, then resume.
		wait_drained();
		send_idle_pct = 75; recv_stall_pct = 35;
		test_random(580);
		send_idle_pct = 0; recv_stall_pct = 0;
		test_random(580);
		wait_drained();
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && expected_rows.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
